/* rtl/core/rrw_pkg.sv */
// Package for the radial ripple image warp: opcodes, queue entry type,
// back-end state type, fixed widths and the ripple offset table.
// Depends on nothing; rrw_front, rrw_queue, rrw_back and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package rrw_pkg;

    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RENDER  = 2'd2;

    localparam int PHASE_COUNT = 24;
    localparam int PHASE_W     = 5;
    localparam int COORD_W     = 10;
    localparam int SUM_W       = 2 * COORD_W + 1;
    localparam int DSQ_W       = 20;
    localparam int DIST_W      = 10;
    localparam int SQRT_STEPS  = 10;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = RECIP_SHIFT + COORD_W;
    localparam logic [PROD_W-1:0] RECIP_PHASE = PROD_W'((1 << RECIP_SHIFT) / PHASE_COUNT);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = 2;

    typedef enum logic [1:0]
    {
        K_ADVANCE,
        K_LOAD,
        K_RENDER
    } kind_t;

    typedef struct packed
    {
        kind_t        kind;
        logic [8:0]   x;
        logic [7:0]   y;
        logic [7:0]   color;
        logic [9:0]   dx;
        logic [9:0]   dy;
    } entry_t;

    typedef enum logic [3:0]
    {
        B_IDLE,
        B_SQ,
        B_ROOT,
        B_MOD,
        B_ALT,
        B_QX,
        B_COL,
        B_QY,
        B_ROW,
        B_READ,
        B_OUT
    } back_state_t;

    function automatic logic signed [4:0] ripple_alt(input logic [4:0] m);
        logic signed [4:0] alt;
        unique case (m)
            5'd0:    alt = 5'sd0;
            5'd1:    alt = 5'sd2;
            5'd2:    alt = 5'sd4;
            5'd3:    alt = 5'sd5;
            5'd4:    alt = 5'sd6;
            5'd5:    alt = 5'sd7;
            5'd6:    alt = 5'sd8;
            5'd7:    alt = 5'sd7;
            5'd8:    alt = 5'sd6;
            5'd9:    alt = 5'sd5;
            5'd10:   alt = 5'sd4;
            5'd11:   alt = 5'sd2;
            5'd12:   alt = 5'sd0;
            5'd13:   alt = -5'sd2;
            5'd14:   alt = -5'sd4;
            5'd15:   alt = -5'sd5;
            5'd16:   alt = -5'sd6;
            5'd17:   alt = -5'sd7;
            5'd18:   alt = -5'sd8;
            5'd19:   alt = -5'sd7;
            5'd20:   alt = -5'sd6;
            5'd21:   alt = -5'sd5;
            5'd22:   alt = -5'sd4;
            5'd23:   alt = -5'sd2;
            default: alt = 5'sd0;
        endcase
        return alt;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rrw_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; used for the image store.
`timescale 1ns / 1ps
`default_nettype none

module rrw_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64000
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/rrw_front.sv */
// Front end: takes input items, drops unused opcodes, and builds queue
// entries with the distances from the image centre. Depends on rrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrw_front
#(
    parameter int IMG_WIDTH  = 320,
    parameter int IMG_HEIGHT = 200
)
(
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      opcode,
    input  logic [8:0]      pixel_x,
    input  logic [7:0]      pixel_y,
    input  logic [7:0]      load_color,
    input  logic            q_full,
    output logic            push,
    output rrw_pkg::entry_t push_entry
);

    import rrw_pkg::*;

    localparam logic signed [COORD_W:0] HALF_W = (COORD_W+1)'(IMG_WIDTH / 2);
    localparam logic signed [COORD_W:0] HALF_H = (COORD_W+1)'(IMG_HEIGHT / 2);

    logic                   accept;
    logic signed [COORD_W:0] diff_x;
    logic signed [COORD_W:0] diff_y;
    logic [COORD_W-1:0]     abs_x;
    logic [COORD_W-1:0]     abs_y;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    assign diff_x = $signed({2'b00, pixel_x}) - HALF_W;
    assign diff_y = $signed({3'b000, pixel_y}) - HALF_H;
    assign abs_x  = diff_x[COORD_W] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
    assign abs_y  = diff_y[COORD_W] ? COORD_W'(-diff_y) : COORD_W'(diff_y);

    always_comb
    begin
        push_entry.kind  = K_RENDER;
        push_entry.x     = pixel_x;
        push_entry.y     = pixel_y;
        push_entry.color = load_color;
        push_entry.dx    = abs_x;
        push_entry.dy    = abs_y;
        push             = 1'b0;
        unique case (opcode)
            OP_ADVANCE:
            begin
                push_entry.kind = K_ADVANCE;
                push            = accept;
            end
            OP_LOAD:
            begin
                push_entry.kind = K_LOAD;
                push            = accept;
            end
            OP_RENDER:
            begin
                push_entry.kind = K_RENDER;
                push            = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rrw_queue.sv */
// Short FIFO of entries between the front end and the back end.
// Depends on rrw_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rrw_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rrw_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rrw_pkg::entry_t head
);

    import rrw_pkg::*;

    entry_t                 slots_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg;
    logic [QUEUE_IDX_W-1:0] wr_ptr_next;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg;
    logic [QUEUE_IDX_W-1:0] rd_ptr_next;
    logic [QUEUE_IDX_W:0]   count_reg;
    logic [QUEUE_IDX_W:0]   count_next;

    assign full       = (count_reg == (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/rrw_back.sv */
// Back end: sequencer that carries out queued entries one at a time, with the
// iterative square root, phase table lookup, address reduction and output register.
// Depends on rrw_pkg; drives the image RAM.
`timescale 1ns / 1ps
`default_nettype none

module rrw_back
#(
    parameter int IMG_WIDTH  = 320,
    parameter int IMG_HEIGHT = 200,
    parameter int ADDR_W     = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  rrw_pkg::entry_t          head,
    output logic                     pop,
    output logic                     ram_we,
    output logic                     ram_re,
    output logic [ADDR_W-1:0]        ram_addr,
    output logic [7:0]               ram_wdata,
    input  logic [7:0]               ram_rdata,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               color,
    output logic signed [4:0]        displacement
);

    import rrw_pkg::*;

    localparam logic [PROD_W-1:0]  RECIP_W = PROD_W'((1 << RECIP_SHIFT) / IMG_WIDTH);
    localparam logic [PROD_W-1:0]  RECIP_H = PROD_W'((1 << RECIP_SHIFT) / IMG_HEIGHT);
    localparam logic [COORD_W:0]   W_C     = (COORD_W+1)'(IMG_WIDTH);
    localparam logic [COORD_W:0]   H_C     = (COORD_W+1)'(IMG_HEIGHT);
    localparam logic [DSQ_W-1:0]   BIT_TOP = DSQ_W'(1) << (2 * (SQRT_STEPS - 1));

    back_state_t              state_reg;
    back_state_t              state_next;
    kind_t                    kind_reg;
    kind_t                    kind_next;
    logic [8:0]               x_reg;
    logic [8:0]               x_next;
    logic [7:0]               y_reg;
    logic [7:0]               y_next;
    logic [7:0]               byte_reg;
    logic [7:0]               byte_next;
    logic [COORD_W-1:0]       dx_reg;
    logic [COORD_W-1:0]       dx_next;
    logic [COORD_W-1:0]       dy_reg;
    logic [COORD_W-1:0]       dy_next;
    logic [DSQ_W-1:0]         rem_reg;
    logic [DSQ_W-1:0]         rem_next;
    logic [DSQ_W-1:0]         root_reg;
    logic [DSQ_W-1:0]         root_next;
    logic [DSQ_W-1:0]         bit_reg;
    logic [DSQ_W-1:0]         bit_next;
    logic [PHASE_W-1:0]       phase_reg;
    logic [PHASE_W-1:0]       phase_next;
    logic [COORD_W-1:0]       quot_reg;
    logic [COORD_W-1:0]       quot_next;
    logic signed [4:0]        alt_reg;
    logic signed [4:0]        alt_next;
    logic signed [COORD_W:0]  sx_reg;
    logic signed [COORD_W:0]  sx_next;
    logic signed [COORD_W:0]  sy_reg;
    logic signed [COORD_W:0]  sy_next;
    logic [COORD_W-1:0]       col_reg;
    logic [COORD_W-1:0]       col_next;
    logic signed [COORD_W:0]  row_reg;
    logic signed [COORD_W:0]  row_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [7:0]               color_reg;
    logic [7:0]               color_next;
    logic signed [4:0]        disp_reg;
    logic signed [4:0]        disp_next;

    logic [DSQ_W:0]           trial;
    logic [PROD_W-1:0]        mul_a;
    logic [PROD_W-1:0]        mul_b;
    logic [PROD_W-1:0]        prod;
    logic [COORD_W:0]         raw24;
    logic [COORD_W:0]         dmod;
    logic [5:0]               m_sum;
    logic [5:0]               m_fix;
    logic signed [4:0]        alt_new;
    logic [COORD_W-1:0]       sx_pos;
    logic [COORD_W:0]         row_pos;
    logic [SUM_W-1:0]         col_raw;
    logic                     col_carry;
    logic [SUM_W-1:0]         col_fix;
    logic [SUM_W-1:0]         rmod_raw;
    logic [SUM_W-1:0]         rmod;
    logic [SUM_W-1:0]         addr_wide;
    logic                     out_take;
    logic                     out_load;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    assign sx_pos  = sx_reg[COORD_W] ? '0 : sx_reg[COORD_W-1:0];
    assign row_pos = row_reg[COORD_W] ? ($unsigned(row_reg) + H_C) : $unsigned(row_reg);

    always_comb
    begin
        mul_a = PROD_W'(root_reg[DIST_W-1:0]);
        mul_b = RECIP_PHASE;
        if (state_reg == B_QX)
        begin
            mul_a = PROD_W'(sx_pos);
            mul_b = RECIP_W;
        end
        else if (state_reg == B_QY)
        begin
            mul_a = PROD_W'(row_pos);
            mul_b = RECIP_H;
        end
    end

    assign prod = mul_a * mul_b;

    assign raw24 = {1'b0, root_reg[DIST_W-1:0]}
                 - (COORD_W+1)'({quot_reg, 4'b0000} + {1'b0, quot_reg, 3'b000});
    assign dmod  = (raw24 >= (COORD_W+1)'(PHASE_COUNT))
                 ? raw24 - (COORD_W+1)'(PHASE_COUNT) : raw24;
    assign m_sum = {1'b0, dmod[PHASE_W-1:0]} + 6'(PHASE_COUNT) - {1'b0, phase_reg};
    assign m_fix = (m_sum >= 6'(PHASE_COUNT)) ? m_sum - 6'(PHASE_COUNT) : m_sum;
    assign alt_new = ripple_alt(m_fix[PHASE_W-1:0]);

    assign col_raw   = SUM_W'(sx_pos) - SUM_W'(quot_reg) * SUM_W'(W_C);
    assign col_carry = (col_raw >= SUM_W'(W_C));
    assign col_fix   = col_carry ? col_raw - SUM_W'(W_C) : col_raw;

    assign rmod_raw = SUM_W'(row_pos) - SUM_W'(quot_reg) * SUM_W'(H_C);
    assign rmod     = (rmod_raw >= SUM_W'(H_C)) ? rmod_raw - SUM_W'(H_C) : rmod_raw;

    assign addr_wide = SUM_W'(row_reg[COORD_W-1:0]) * SUM_W'(W_C) + SUM_W'(col_reg);

    assign out_take = out_valid_reg & ~out_stall;
    assign out_load = (state_reg == B_OUT) & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        byte_next      = byte_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        quot_next      = quot_reg;
        alt_next       = alt_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        color_next     = color_reg;
        disp_next      = disp_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_valid_next = out_load ? 1'b1 : (out_take ? 1'b0 : out_valid_reg);

        unique case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    pop       = 1'b1;
                    kind_next = head.kind;
                    x_next    = head.x;
                    y_next    = head.y;
                    byte_next = head.color;
                    dx_next   = head.dx;
                    dy_next   = head.dy;
                    unique case (head.kind)
                        K_ADVANCE:
                        begin
                            phase_next = (phase_reg == PHASE_W'(PHASE_COUNT - 1))
                                       ? '0 : phase_reg + 1'b1;
                        end
                        K_LOAD:
                        begin
                            sx_next    = $signed({2'b00, head.x});
                            sy_next    = $signed({3'b000, head.y});
                            state_next = B_QX;
                        end
                        K_RENDER:
                        begin
                            state_next = B_SQ;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_SQ:
            begin
                rem_next   = DSQ_W'(dx_reg) * DSQ_W'(dx_reg) + DSQ_W'(dy_reg) * DSQ_W'(dy_reg);
                root_next  = '0;
                bit_next   = BIT_TOP;
                state_next = B_ROOT;
            end
            B_ROOT:
            begin
                if ({1'b0, rem_reg} >= trial)
                begin
                    rem_next  = rem_reg - trial[DSQ_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = B_MOD;
                end
            end
            B_MOD:
            begin
                quot_next  = prod[RECIP_SHIFT +: COORD_W];
                state_next = B_ALT;
            end
            B_ALT:
            begin
                alt_next   = alt_new;
                sx_next    = $signed({2'b00, x_reg}) + (COORD_W+1)'(alt_new);
                sy_next    = $signed({3'b000, y_reg}) + (COORD_W+1)'(alt_new);
                state_next = B_QX;
            end
            B_QX:
            begin
                quot_next  = prod[RECIP_SHIFT +: COORD_W];
                state_next = B_COL;
            end
            B_COL:
            begin
                if (sx_reg[COORD_W])
                begin
                    col_next = COORD_W'($unsigned(sx_reg) + W_C);
                    row_next = sy_reg - (COORD_W+1)'(1);
                end
                else
                begin
                    col_next = col_fix[COORD_W-1:0];
                    row_next = sy_reg
                             + $signed((COORD_W+1)'(quot_reg) + (COORD_W+1)'(col_carry));
                end
                state_next = B_QY;
            end
            B_QY:
            begin
                quot_next  = prod[RECIP_SHIFT +: COORD_W];
                state_next = B_ROW;
            end
            B_ROW:
            begin
                row_next   = $signed(rmod[COORD_W:0]);
                state_next = B_READ;
            end
            B_READ:
            begin
                if (kind_reg == K_LOAD)
                begin
                    ram_we     = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    color_next = ram_rdata;
                    disp_next  = alt_reg;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        byte_reg  <= byte_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        quot_reg  <= quot_next;
        alt_reg   <= alt_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        color_reg <= color_next;
        disp_reg  <= disp_next;
    end

    assign ram_addr     = addr_wide[ADDR_W-1:0];
    assign ram_wdata    = byte_reg;
    assign out_valid    = out_valid_reg;
    assign color        = color_reg;
    assign displacement = disp_reg;

endmodule

`default_nettype wire

/* rtl/core/radial_ripple_image_warp.sv */
// Top level of the radial ripple image warp: front end, entry queue, back end
// and image RAM. Depends on rrw_pkg, rrw_front, rrw_queue, rrw_back and rrw_ram.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   opcode, pixel_x, pixel_y, load_color
//   output   out_valid / out_stall color, displacement
//
// The back end handles one queued item at a time; a render runs the square root, which
// resolves one result bit per cycle, before the address states that a load also runs;
// the single image RAM port takes one access per load or render, none per advance.
// A four-item queue lets the input side keep accepting while the back end works or
// while a finished result waits under out_stall.
// Reset clears the queue, the frame phase and the output valid; the image is
// undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module radial_ripple_image_warp
#(
    parameter int IMG_WIDTH  = 320,
    parameter int IMG_HEIGHT = 200
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [8:0]        pixel_x,
    input  logic [7:0]        pixel_y,
    input  logic [7:0]        load_color,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        color,
    output logic signed [4:0] displacement
);

    import rrw_pkg::*;

    localparam int STORE_DEPTH = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic              q_full;
    logic              push;
    entry_t            push_entry;
    logic              pop;
    logic              head_valid;
    entry_t            head;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    rrw_front
    #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    )
    u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .load_color (load_color),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    rrw_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    rrw_back
    #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .ADDR_W     (ADDR_W)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .ram_we       (ram_we),
        .ram_re       (ram_re),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .color        (color),
        .displacement (displacement)
    );

    rrw_ram
    #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    )
    u_image
    (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

/* rtl/core/rrw_checker.sv */
// Port-level checks for the radial ripple image warp, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module rrw_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [7:0]        color,
    input logic signed [4:0] displacement
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(color) && $stable(displacement))
        else $error("output payload changed while stalled");

    a_disp_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (displacement >= -5'sd8) && (displacement <= 5'sd8)
                      && (displacement != 5'sd1) && (displacement != -5'sd1)
                      && (displacement != 5'sd3) && (displacement != -5'sd3))
        else $error("displacement is not a ripple table value");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_stall && !out_valid)
        else $error("queue or output not empty after reset");

    a_in_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_stall))
        else $error("input stall unknown while an item is offered");

endmodule

bind radial_ripple_image_warp rrw_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .color        (color),
    .displacement (displacement)
);

`default_nettype wire
